// File: rtl/jri_pkg.sv
// Package for the restart marker indexer: item types, phase codes and constants.
`timescale 1ns / 1ps

package jri_pkg;

    // Offset counter width default
    localparam int OFFSET_WIDTH_DEF = 32;

    // Field widths fixed by the item formats
    localparam int CNT_W    = 13;
    localparam int TILE_W   = 12;
    localparam int TNUM_W   = 24;
    localparam int OUTOFS_W = 32;
    localparam int LEN_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Clamp limit for the tile counts
    localparam logic [CNT_W-1:0] CNT_MAX = 13'd4096;

    // Marker bytes and masks
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] MARK_SOI   = 8'hD8;
    localparam logic [7:0] MARK_SOF0  = 8'hC0;
    localparam logic [7:0] MARK_SOS   = 8'hDA;
    localparam logic [3:0] RST_HI     = 4'hD;
    localparam logic [7:0] PRECISION8 = 8'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_PER_ROW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SIZE  = 2'd0;
    localparam logic [1:0] KIND_TILE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NO_SOI     = 3'd0;
    localparam logic [2:0] ERR_MISSING_FF = 3'd1;
    localparam logic [2:0] ERR_PRECISION  = 3'd2;
    localparam logic [2:0] ERR_COMPONENTS = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

    // Parser phase
    typedef enum logic [3:0] {
        PH_SOI0,
        PH_SOI1,
        PH_HEADER,
        PH_SKIP,
        PH_SCAN,
        PH_STOP
    } t_phase;

    // Position inside a marker segment header
    typedef enum logic [2:0] {
        SEG_FF,
        SEG_CODE,
        SEG_LEN_HI,
        SEG_LEN_LO,
        SEG_DETAIL
    } t_seg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          kind;
        logic [TNUM_W-1:0]   tile_number;
        logic [OUTOFS_W-1:0] byte_offset;
        logic [2:0]          error_code;
        logic                index_done;
    } t_out_item;

    // Tile count as used: zero acts as one, above the limit as the limit
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_MAX) begin
            r = CNT_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/jpeg_restart_marker_indexer.sv
// JPEG restart marker indexer: parses a JPEG byte stream and reports tile entry offsets.
`timescale 1ns / 1ps

// Takes one file byte per cycle and never stalls the input while the output side
// takes results: each byte is parsed in the cycle it is accepted and its result
// (at most one) is registered into the output buffer. A two-slot output buffer
// holds results while the output is stalled; input ready drops only when both slots
// are full. Reported items: the offset of the SOF0 size field, the start of the
// entropy data as tile 0, the offset after each in-sequence restart marker as the
// next tile, and errors. After an error or the last tile every byte is dropped until
// reset. Byte offsets count modulo 2**OFFSET_WIDTH and are shown in 32 bits. The user
// must write configuration via cfg port only while no item is in flight (not enforced).
module jpeg_restart_marker_indexer
    import jri_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CNT_W-1:0]     i_cfg_wdata
);

    // configuration registers
    logic [CNT_W-1:0] r_tpr_cfg, r_trows_cfg;
    logic [2:0]       r_ccount;

    // parser state
    t_phase              r_phase, n_phase;
    t_seg                r_seg, n_seg;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [7:0]          r_marker, n_marker;
    logic [7:0]          r_len_hi, n_len_hi;
    logic [TILE_W-1:0]   r_col, n_col;
    logic [TILE_W-1:0]   r_row, n_row;
    logic [2:0]          r_exp, n_exp;
    logic                r_prev_ff, n_prev_ff;

    // output buffer: head slot and skid slot
    logic      r_ov, r_sv;
    t_out_item r_head, r_skid;

    // per-byte decode
    logic                    acc;
    logic [7:0]              b;
    logic                    eof;
    logic [CNT_W-1:0]        tpr, trows;
    logic [OFFSET_WIDTH-1:0] pos_inc;
    logic [OFFSET_WIDTH+OUTOFS_W-1:0] ext_here, ext_next;
    logic [OUTOFS_W-1:0]     off_here, off_next;
    logic [LEN_W-1:0]        len_full;
    logic [LEN_W-1:0]        rem_dec;
    logic                    is_hdr_mark;
    logic                    single_tile;
    logic                    rst_match;
    logic [TILE_W-1:0]       col_inc, inc_col, inc_row;
    logic                    col_wrap;
    logic                    inc_done;
    logic [TNUM_W:0]         tile_prod, tile_sum;

    // result of the current byte
    logic      res_v;
    t_out_item res;

    assign acc        = i_in_valid && o_in_ready;
    assign o_in_ready = !r_sv;
    assign b          = i_in_item.data_byte;
    assign eof        = i_in_item.end_of_file;

    assign tpr   = eff_count(r_tpr_cfg);
    assign trows = eff_count(r_trows_cfg);

    // byte offsets, wrapped to the counter width then shown in 32 bits
    assign pos_inc  = r_pos + 1'b1;
    assign ext_here = {{OUTOFS_W{1'b0}}, r_pos};
    assign ext_next = {{OUTOFS_W{1'b0}}, pos_inc};
    assign off_here = ext_here[OUTOFS_W-1:0];
    assign off_next = ext_next[OUTOFS_W-1:0];

    // segment length handling
    assign len_full    = {r_len_hi, b};
    assign is_hdr_mark = (r_marker == MARK_SOF0) || (r_marker == MARK_SOS);
    assign rem_dec     = (r_rem != '0) ? r_rem - 1'b1 : '0;
    assign single_tile = (tpr == CNT_W'(1)) && (trows == CNT_W'(1));

    // restart marker in sequence
    assign rst_match = r_prev_ff && (b[7:4] == RST_HI) && (b[3:0] == {1'b0, r_exp});

    // tile advance
    assign col_inc  = r_col + 1'b1;
    assign col_wrap = {1'b0, col_inc} >= tpr;
    assign inc_col  = col_wrap ? '0 : col_inc;
    assign inc_row  = col_wrap ? r_row + 1'b1 : r_row;
    assign inc_done = ({1'b0, inc_row} == trows - 1'b1) &&
                      ({1'b0, inc_col} == tpr - 1'b1);
    assign tile_prod = (TNUM_W+1)'(inc_row) * (TNUM_W+1)'(tpr);
    assign tile_sum  = tile_prod + (TNUM_W+1)'(inc_col);

    // next parser state
    always_comb begin
        n_phase   = r_phase;
        n_seg     = r_seg;
        n_pos     = pos_inc;
        n_rem     = r_rem;
        n_marker  = r_marker;
        n_len_hi  = r_len_hi;
        n_col     = r_col;
        n_row     = r_row;
        n_exp     = r_exp;
        n_prev_ff = r_prev_ff;
        case (r_phase)
            PH_SOI0: begin
                n_phase = (b == BYTE_FF) ? PH_SOI1 : PH_STOP;
            end
            PH_SOI1: begin
                if (b == MARK_SOI) begin
                    n_phase = PH_HEADER;
                    n_seg   = SEG_FF;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_HEADER: begin
                case (r_seg)
                    SEG_FF: begin
                        if (b == BYTE_FF) begin
                            n_seg = SEG_CODE;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                    SEG_CODE: begin
                        n_marker = b;
                        n_seg    = SEG_LEN_HI;
                    end
                    SEG_LEN_HI: begin
                        n_len_hi = b;
                        n_seg    = SEG_LEN_LO;
                    end
                    SEG_LEN_LO: begin
                        if (is_hdr_mark) begin
                            n_rem = (len_full >= LEN_W'(3)) ? len_full - LEN_W'(3) : '0;
                            n_seg = SEG_DETAIL;
                        end else begin
                            n_rem = (len_full >= LEN_W'(2)) ? len_full - LEN_W'(2) : '0;
                            n_seg = SEG_FF;
                            if (n_rem != '0) begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    SEG_DETAIL: begin
                        n_seg = SEG_FF;
                        if (r_marker == MARK_SOF0) begin
                            if (b != PRECISION8) begin
                                n_phase = PH_STOP;
                            end else if (r_rem != '0) begin
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            if (b != {5'b0, r_ccount}) begin
                                n_phase = PH_STOP;
                            end else if (r_rem == '0) begin
                                // scan starts right after the header
                                n_col     = '0;
                                n_row     = '0;
                                n_exp     = '0;
                                n_prev_ff = 1'b0;
                                n_phase   = single_tile ? PH_STOP : PH_SCAN;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    default: begin
                        n_seg = SEG_FF;
                    end
                endcase
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_seg = SEG_FF;
                    if (r_marker == MARK_SOS) begin
                        n_col     = '0;
                        n_row     = '0;
                        n_exp     = '0;
                        n_prev_ff = 1'b0;
                        n_phase   = single_tile ? PH_STOP : PH_SCAN;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
            end
            PH_SCAN: begin
                if (rst_match) begin
                    n_col = inc_col;
                    n_row = inc_row;
                    n_exp = r_exp + 1'b1;
                    if (inc_done) begin
                        n_phase = PH_STOP;
                    end
                end
                n_prev_ff = (b == BYTE_FF);
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
        // end of file before the index is complete
        if (eof) begin
            n_phase = PH_STOP;
        end
    end

    // result of the current byte
    always_comb begin
        res_v = 1'b0;
        res   = '0;
        case (r_phase)
            PH_SOI0: begin
                if (b != BYTE_FF) begin
                    res_v = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.byte_offset = off_here;
                    res.error_code  = ERR_NO_SOI;
                end
            end
            PH_SOI1: begin
                if (b != MARK_SOI) begin
                    res_v = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.byte_offset = off_here;
                    res.error_code  = ERR_NO_SOI;
                end
            end
            PH_HEADER: begin
                if (r_seg == SEG_FF) begin
                    if (b != BYTE_FF) begin
                        res_v = 1'b1;
                        res.kind        = KIND_ERROR;
                        res.byte_offset = off_here;
                        res.error_code  = ERR_MISSING_FF;
                    end
                end else if (r_seg == SEG_DETAIL) begin
                    res_v = 1'b1;
                    if (r_marker == MARK_SOF0) begin
                        if (b != PRECISION8) begin
                            res.kind        = KIND_ERROR;
                            res.byte_offset = off_here;
                            res.error_code  = ERR_PRECISION;
                        end else begin
                            res.kind        = KIND_SIZE;
                            res.byte_offset = off_next;
                        end
                    end else if (b != {5'b0, r_ccount}) begin
                        res.kind        = KIND_ERROR;
                        res.byte_offset = off_here;
                        res.error_code  = ERR_COMPONENTS;
                    end else if (r_rem == '0) begin
                        res.kind        = KIND_TILE;
                        res.byte_offset = off_next;
                        res.index_done  = single_tile;
                    end else begin
                        res_v = 1'b0;
                    end
                end
            end
            PH_SKIP: begin
                if (rem_dec == '0 && r_marker == MARK_SOS) begin
                    res_v = 1'b1;
                    res.kind        = KIND_TILE;
                    res.byte_offset = off_next;
                    res.index_done  = single_tile;
                end
            end
            PH_SCAN: begin
                if (rst_match) begin
                    res_v = 1'b1;
                    res.kind        = KIND_TILE;
                    res.tile_number = tile_sum[TNUM_W-1:0];
                    res.byte_offset = off_next;
                    res.index_done  = inc_done;
                end
            end
            default: begin
                res_v = 1'b0;
            end
        endcase
        // truncation replaces anything but an error of the byte itself or the item that ends the index
        if (eof && r_phase != PH_STOP &&
            !(res_v && res.kind == KIND_ERROR) && !(res_v && res.index_done)) begin
            res_v = 1'b1;
            res   = '0;
            res.kind        = KIND_ERROR;
            res.byte_offset = off_here;
            res.error_code  = ERR_TRUNCATED;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpr_cfg   <= CNT_W'(1);
            r_trows_cfg <= CNT_W'(1);
            r_ccount    <= 3'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TILES_PER_ROW:   r_tpr_cfg   <= i_cfg_wdata;
                CFG_TILE_ROWS:       r_trows_cfg <= i_cfg_wdata;
                CFG_COMPONENT_COUNT: r_ccount    <= i_cfg_wdata[2:0];
                default:             r_ccount    <= r_ccount;
            endcase
        end
    end

    // parser state, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SOI0;
            r_seg     <= SEG_FF;
            r_pos     <= '0;
            r_rem     <= '0;
            r_marker  <= '0;
            r_len_hi  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_exp     <= '0;
            r_prev_ff <= 1'b0;
        end else if (acc) begin
            r_phase   <= n_phase;
            r_seg     <= n_seg;
            r_pos     <= n_pos;
            r_rem     <= n_rem;
            r_marker  <= n_marker;
            r_len_hi  <= n_len_hi;
            r_col     <= n_col;
            r_row     <= n_row;
            r_exp     <= n_exp;
            r_prev_ff <= n_prev_ff;
        end
    end

    // two-slot output buffer; input is refused only while the skid slot is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) begin
                if (r_sv) begin
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= acc && res_v;
                end
            end else if (acc && res_v) begin
                if (r_ov) begin
                    r_sv <= 1'b1;
                end else begin
                    r_ov <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && i_out_ready) begin
            if (r_sv) begin
                r_head <= r_skid;
            end else begin
                r_head <= res;
            end
        end else if (acc && res_v) begin
            if (r_ov) begin
                r_skid <= res;
            end else begin
                r_head <= res;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_head;

endmodule

// File: rtl/jri_checker.sv
// Port-level checker for the restart marker indexer, bound to the top level.
`timescale 1ns / 1ps

module jri_checker
    import jri_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_item
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // input is refused only while results are queued
    a_ready_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input refused with empty output");

    // error code is zero unless the item is an error
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind != KIND_ERROR |-> o_out_item.error_code == 3'd0)
        else $error("error code on a non-error item");

    // only tile entries finish the index
    a_done_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.index_done |-> o_out_item.kind == KIND_TILE)
        else $error("index done on a non-tile item");

endmodule

bind jpeg_restart_marker_indexer jri_checker u_jri_checker (.*);
